@@ design/lrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lrt_pkg;

  // Field widths
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 8;
  localparam int FRAC_W     = 16;
  localparam int SCORE_W    = 15;
  localparam int AREA_W     = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int RAD_CFG_W  = 6;

  // Internal widths, bounded by the field widths and the radius range
  localparam int COORD_W      = 10;  // col + radius and image size minus one
  localparam int RAD_W        = 7;   // clamped radius up to 63
  localparam int DIM_W        = 8;   // clipped window side up to 127
  localparam int SCORE_FULL_W = 17;  // up to twice the window area
  localparam int AREA_FULL_W  = 2 * DIM_W;
  localparam int FRAC_SHIFT   = 15;  // score * 32768
  localparam int DIVIDEND_W   = SCORE_FULL_W + FRAC_SHIFT;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [RAD_CFG_W-1:0]  RADIUS_RESET = 6'd15;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 9'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } lrt_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // input transfer this cycle
    logic setup;      // latch centre, area, scan start
    logic scan;       // issue one window read
    logic div_start;  // launch the divider
    logic load_out;   // load the output register
  } lrt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic bad;
    logic scan_last;
    logic div_done;
    logic out_free;
  } lrt_stat_t;

endpackage

`default_nettype wire

@@ design/lrt_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrt_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [lrt_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [lrt_pkg::AREA_FULL_W-1:0]  divisor,
  output logic                                  done,
  output logic [lrt_pkg::FRAC_W-1:0]            quotient
);

  localparam int CNT_W = $clog2(lrt_pkg::DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lrt_pkg::DIVIDEND_W - 1);

  logic                                busy;
  logic [CNT_W-1:0]                    cnt;
  logic [lrt_pkg::AREA_FULL_W-1:0]     rem;
  logic [lrt_pkg::DIVIDEND_W-1:0]      quo;
  logic [lrt_pkg::AREA_FULL_W:0]       shifted;
  logic [lrt_pkg::AREA_FULL_W:0]       diff;
  logic                                fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem, quo[lrt_pkg::DIVIDEND_W-1]};
    fits    = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  // Control: busy over one step per dividend bit, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[lrt_pkg::AREA_FULL_W-1:0] : shifted[lrt_pkg::AREA_FULL_W-1:0];
      quo <= {quo[lrt_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo[lrt_pkg::FRAC_W-1:0];

endmodule

`default_nettype wire

@@ design/lrt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lrt_pkg::lrt_stat_t stat,
  output lrt_pkg::lrt_cmd_t       cmd
);

  lrt_pkg::lrt_state_t state;
  lrt_pkg::lrt_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      lrt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && stat.is_query) begin
          state_next = lrt_pkg::ST_SETUP;
        end
      end
      lrt_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = stat.bad ? lrt_pkg::ST_OUT : lrt_pkg::ST_SCAN;
      end
      lrt_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = lrt_pkg::ST_DRAIN;
        end
      end
      lrt_pkg::ST_DRAIN: begin
        state_next = lrt_pkg::ST_DIV_START;
      end
      lrt_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = lrt_pkg::ST_DIV_WAIT;
      end
      lrt_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_next = lrt_pkg::ST_OUT;
        end
      end
      lrt_pkg::ST_OUT: begin
        // Hold until the previous result has been taken
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = lrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/lrt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrt_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 50
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [lrt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lrt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               kind,
  input  wire logic [lrt_pkg::POS_W-1:0]          col,
  input  wire logic [lrt_pkg::POS_W-1:0]          row,
  input  wire logic [lrt_pkg::VALUE_W-1:0]        value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [lrt_pkg::FRAC_W-1:0]              rank_fraction,
  output logic [lrt_pkg::SCORE_W-1:0]             score,
  output logic [lrt_pkg::AREA_W-1:0]              window_area,
  output logic                                    bad_position,
  input  wire lrt_pkg::lrt_cmd_t                  cmd,
  output lrt_pkg::lrt_stat_t                      stat
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = lrt_pkg::COORD_W;

  // Configuration registers
  logic [lrt_pkg::RAD_CFG_W-1:0]  radius;
  logic [lrt_pkg::CFG_DATA_W-1:0] image_width;
  logic [lrt_pkg::CFG_DATA_W-1:0] image_height;

  // Effective settings after clamping
  logic [lrt_pkg::RAD_W-1:0] rad;
  logic [CW-1:0]             w_eff;
  logic [CW-1:0]             h_eff;

  // Query bounds and scan position
  logic [CW-1:0] qcol;
  logic [CW-1:0] qrow;
  logic [CW-1:0] col_r;
  logic [CW-1:0] row_r;
  logic [CW-1:0] x0_next;
  logic [CW-1:0] x1_next;
  logic [CW-1:0] y0_next;
  logic [CW-1:0] y1_next;
  logic [CW-1:0] x0;
  logic [CW-1:0] x1;
  logic [CW-1:0] y0;
  logic [CW-1:0] y1;
  logic [CW-1:0] x;
  logic [CW-1:0] y;
  logic          bad;
  logic [CW-1:0] dx_full;
  logic [CW-1:0] dy_full;

  // Pixel memory
  logic [lrt_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               in_addr;
  logic [AW-1:0]               scan_addr;
  logic                        wr_ok;
  logic [lrt_pkg::VALUE_W-1:0] rdata;
  logic                        rd_pending;

  // Accumulation and divide
  logic [lrt_pkg::VALUE_W-1:0]     centre;
  logic [lrt_pkg::AREA_FULL_W-1:0] area;
  logic [lrt_pkg::SCORE_FULL_W-1:0] acc;
  logic                            div_done;
  logic [lrt_pkg::FRAC_W-1:0]      quotient;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= lrt_pkg::RADIUS_RESET;
      image_width  <= lrt_pkg::WIDTH_RESET;
      image_height <= lrt_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lrt_pkg::REG_RADIUS:       radius       <= cfg_data[lrt_pkg::RAD_CFG_W-1:0];
        lrt_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        lrt_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp radius to 1..MAX_RADIUS and image size to what the store holds
  always_comb begin
    if (radius == '0) begin
      rad = lrt_pkg::RAD_W'(1);
    end else if (int'(radius) > MAX_RADIUS) begin
      rad = lrt_pkg::RAD_W'(MAX_RADIUS);
    end else begin
      rad = lrt_pkg::RAD_W'(radius);
    end
    w_eff = (int'(image_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(image_width);
    h_eff = (int'(image_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(image_height);
  end

  // Clip the window to the image
  always_comb begin
    qcol    = CW'(col);
    qrow    = CW'(row);
    col_r   = qcol + CW'(rad);
    row_r   = qrow + CW'(rad);
    x0_next = (qcol > CW'(rad)) ? qcol - CW'(rad) : '0;
    y0_next = (qrow > CW'(rad)) ? qrow - CW'(rad) : '0;
    x1_next = (col_r < w_eff - 1'b1) ? col_r : w_eff - 1'b1;
    y1_next = (row_r < h_eff - 1'b1) ? row_r : h_eff - 1'b1;
    dx_full = x1 - x0 + 1'b1;
    dy_full = y1 - y0 + 1'b1;
  end

  // Latch query bounds at the input transfer
  always_ff @(posedge clk) begin
    if (cmd.take && kind == lrt_pkg::KIND_QUERY) begin
      x0  <= x0_next;
      x1  <= x1_next;
      y0  <= y0_next;
      y1  <= y1_next;
      bad <= (qcol >= w_eff) || (qrow >= h_eff);
    end
  end

  // Memory addressing: scan position while scanning, input position otherwise
  always_comb begin
    in_addr   = AW'(int'(row) * MAX_WIDTH + int'(col));
    scan_addr = AW'(int'(y) * MAX_WIDTH + int'(x));
    rd_addr   = cmd.scan ? scan_addr : in_addr;
    wr_ok     = cmd.take && (kind == lrt_pkg::KIND_WRITE) &&
                (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
  end

  // Pixel store: one registered read a cycle, plus a write on a write item
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[in_addr] <= value;
    end
    rdata <= mem[rd_addr];
  end

  // Track which read data belongs to the window scan
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.scan;
    end
  end

  // Set up the scan, walk the window row by row, accumulate the score
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      centre <= rdata;
      x      <= x0;
      y      <= y0;
      area   <= dx_full[lrt_pkg::DIM_W-1:0] * dy_full[lrt_pkg::DIM_W-1:0];
      acc    <= '0;
    end else begin
      if (cmd.scan) begin
        if (x == x1) begin
          x <= x0;
          y <= y + 1'b1;
        end else begin
          x <= x + 1'b1;
        end
      end
      if (rd_pending) begin
        if ($signed(rdata) < $signed(centre)) begin
          acc <= acc + lrt_pkg::SCORE_FULL_W'(2);
        end else if (rdata == centre) begin
          acc <= acc + lrt_pkg::SCORE_FULL_W'(1);
        end
      end
    end
  end

  // score * 32768 / area
  lrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({acc, {lrt_pkg::FRAC_SHIFT{1'b0}}}),
    .divisor  (area),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      bad_position <= bad;
      if (bad) begin
        rank_fraction <= '0;
        score         <= '0;
        window_area   <= '0;
      end else begin
        rank_fraction <= quotient;
        score         <= acc[lrt_pkg::SCORE_W-1:0];
        window_area   <= area[lrt_pkg::AREA_W-1:0];
      end
    end
  end

  // Status to the controller
  always_comb begin
    stat.is_query  = (kind == lrt_pkg::KIND_QUERY);
    stat.bad       = bad;
    stat.scan_last = (x == x1) && (y == y1);
    stat.div_done  = div_done;
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

@@ design/local_rank_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Local rank transform over a stored frame. A write item (kind 0) stores one
// signed pixel at (col, row); writes stream at one per clock while no query
// is in progress. A query item (kind 1) scores every pixel of the square
// window of the configured radius around (col, row), clipped to the
// configured image: 2 per smaller pixel, 1 per equal one, the centre included.
// The window is read from the single-port pixel memory one pixel per cycle,
// and the fraction score*32768/area comes from a bit-serial divider of 32
// steps; a query keeps the input stalled until its result is loaded into the
// output register. A query outside the image skips the scan and the divide
// and returns bad_position with zero fields. The result sits in an output
// register, and the block takes further items while it waits there. Pixels
// must be written before a query reads them; the memory is not cleared. Write
// configuration only while the block is idle.
module local_rank_transform #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 50
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lrt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            kind,
  input  wire logic [lrt_pkg::POS_W-1:0]       col,
  input  wire logic [lrt_pkg::POS_W-1:0]       row,
  input  wire logic [lrt_pkg::VALUE_W-1:0]     value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lrt_pkg::FRAC_W-1:0]           rank_fraction,
  output logic [lrt_pkg::SCORE_W-1:0]          score,
  output logic [lrt_pkg::AREA_W-1:0]           window_area,
  output logic                                 bad_position
);

  lrt_pkg::lrt_cmd_t  cmd;
  lrt_pkg::lrt_stat_t stat;

  lrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrt_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .col           (col),
    .row           (row),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rank_fraction (rank_fraction),
    .score         (score),
    .window_area   (window_area),
    .bad_position  (bad_position),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

`default_nettype wire

@@ design/lrt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrt_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            kind,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [lrt_pkg::FRAC_W-1:0]      rank_fraction,
  input wire logic [lrt_pkg::SCORE_W-1:0]     score,
  input wire logic [lrt_pkg::AREA_W-1:0]      window_area,
  input wire logic                            bad_position
);

  // A stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rank_fraction) &&
      $stable(score) && $stable(window_area) && $stable(bad_position))
    else $error("stalled result changed");

  // A position outside the image gives all-zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_position |-> rank_fraction == '0 && score == '0 &&
      window_area == '0)
    else $error("bad position with nonzero fields");

  // A query transfer keeps the input stalled on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == lrt_pkg::KIND_QUERY |=> in_stall)
    else $error("input taken right after a query");

  // A new result appears only at the end of query work
  a_out_after_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without query work");

endmodule

bind local_rank_transform lrt_checker u_lrt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .kind          (kind),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .rank_fraction (rank_fraction),
  .score         (score),
  .window_area   (window_area),
  .bad_position  (bad_position)
);

`default_nettype wire
